/* rtl/core/tmse_pkg.sv */
package tmse_pkg;

   localparam int TAPE_LEN    = 1024;
   localparam int MAX_SYMBOLS = 16;
   localparam int MAX_STATES  = 9;
   localparam int RULE_DEPTH  = MAX_STATES * MAX_SYMBOLS;

   localparam int HEAD_W  = $clog2(TAPE_LEN);
   localparam int RULE_AW = $clog2(RULE_DEPTH);
   localparam int STATE_W = 4;
   localparam int COL_W   = 4;
   localparam int SYM_W   = 8;
   localparam int ASIZE_W = 5;

   localparam logic [SYM_W-1:0]   BLANK_RESET = 8'd32;
   localparam logic [HEAD_W-1:0]  HEAD_RESET  = HEAD_W'(TAPE_LEN / 2);
   localparam logic [STATE_W-1:0] STATE_START = 4'd1;
   localparam logic [STATE_W-1:0] STATE_HALT  = 4'd0;

   typedef enum logic [2:0] {
      FUNC_RULE     = 3'd0,
      FUNC_TAPE     = 3'd1,
      FUNC_ALPHABET = 3'd2,
      FUNC_STEP     = 3'd3,
      FUNC_HEAD     = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      OUT_OK       = 2'd0,
      OUT_HALT     = 2'd1,
      OUT_NO_SYM   = 2'd2,
      OUT_NO_RULE  = 2'd3
   } outcome_type;

   localparam logic [1:0] MOVE_RIGHT = 2'd1;
   localparam logic [1:0] MOVE_LEFT  = 2'd2;

   localparam logic CSR_ALPHABET_SIZE = 1'b0;
   localparam logic CSR_BLANK_SYMBOL  = 1'b1;

   typedef struct packed {
      logic               present;
      logic [SYM_W-1:0]   sym;
      logic [1:0]         move;
      logic [STATE_W-1:0] next;
   } rule_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic look;
      logic apply;
   } cmd_type;

endpackage

/* rtl/core/turing_machine_step_engine.sv */
// Single-tape Turing machine with a 1024-cell ring tape, 9 states and 16 alphabet slots.
// After reset the block runs a clearing pass that fills the tape with the blank symbol;
// busy is high until it ends, and only configuration writes are taken then. An item is
// taken when start is high and busy is low. A load item keeps busy low, and its result
// appears on the rsp_ ports in the next cycle. A step item passes through the tape
// memory read, then the rule memory read, then the tape write; busy is high in the look
// and apply states after acceptance, and the result appears once the block is idle
// again, while the next item may already be taken. Each result is valid for exactly one
// cycle under rsp_valid and cannot be held off by the receiver.
module turing_machine_step_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_func,
   input  logic [3:0] req_rule_state,
   input  logic [3:0] req_column_index,
   input  logic [9:0] req_cell_position,
   input  logic [7:0] req_symbol,
   input  logic [1:0] req_move_dir,
   input  logic [3:0] req_next_state,
   input  logic       req_rule_present,
   output logic       rsp_valid,
   output logic [1:0] rsp_outcome,
   output logic [9:0] rsp_head_now,
   output logic [3:0] rsp_state_now,
   output logic [7:0] rsp_symbol_written
);

   import tmse_pkg::*;

   cmd_type cmd;
   logic    clear_done;

   tmse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_func   (req_func),
      .clear_done (clear_done),
      .busy       (busy),
      .cmd        (cmd)
   );

   tmse_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .clear_done         (clear_done),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_func           (req_func),
      .req_rule_state     (req_rule_state),
      .req_column_index   (req_column_index),
      .req_cell_position  (req_cell_position),
      .req_symbol         (req_symbol),
      .req_move_dir       (req_move_dir),
      .req_next_state     (req_next_state),
      .req_rule_present   (req_rule_present),
      .rsp_valid          (rsp_valid),
      .rsp_outcome        (rsp_outcome),
      .rsp_head_now       (rsp_head_now),
      .rsp_state_now      (rsp_state_now),
      .rsp_symbol_written (rsp_symbol_written)
   );

endmodule

/* rtl/core/tmse_ram.sv */
module tmse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/tmse_ctrl.sv */
module tmse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [2:0]       req_func,
   input  logic             clear_done,
   output logic             busy,
   output tmse_pkg::cmd_type cmd
);

   import tmse_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_APPLY = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_func == FUNC_STEP)) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK:  state_in = ST_APPLY;
         ST_APPLY: state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.clear = (state_ff == ST_CLEAR);
      cmd.load  = accept && (req_func != FUNC_STEP);
      cmd.look  = (state_ff == ST_LOOK);
      cmd.apply = (state_ff == ST_APPLY);
   end

endmodule

/* rtl/core/tmse_dpath.sv */
module tmse_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  tmse_pkg::cmd_type                 cmd,
   output logic                              clear_done,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [7:0]                        csr_wdata,
   input  logic [2:0]                        req_func,
   input  logic [3:0]                        req_rule_state,
   input  logic [3:0]                        req_column_index,
   input  logic [9:0]                        req_cell_position,
   input  logic [7:0]                        req_symbol,
   input  logic [1:0]                        req_move_dir,
   input  logic [3:0]                        req_next_state,
   input  logic                              req_rule_present,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_outcome,
   output logic [9:0]                        rsp_head_now,
   output logic [3:0]                        rsp_state_now,
   output logic [7:0]                        rsp_symbol_written
);

   import tmse_pkg::*;

   localparam int RULE_W = $bits(rule_type);

   logic [ASIZE_W-1:0]  alpha_size_ff;
   logic [SYM_W-1:0]    alpha_ff [MAX_SYMBOLS];
   logic [RULE_DEPTH-1:0] rule_vld_ff;

   logic [HEAD_W-1:0]   head_ff, head_in;
   logic [STATE_W-1:0]  state_ff, state_in;
   logic [HEAD_W-1:0]   clr_addr_ff, clr_addr_in;

   logic [SYM_W-1:0]    cur_ff;
   logic                found_ff;
   logic                vld_rd_ff;

   logic                rsp_valid_ff;
   logic [1:0]          rsp_outcome_ff, rsp_outcome_in;
   logic [HEAD_W-1:0]   rsp_head_ff;
   logic [STATE_W-1:0]  rsp_state_ff;
   logic [SYM_W-1:0]    rsp_sym_ff, rsp_sym_in;

   logic                tape_we;
   logic [HEAD_W-1:0]   tape_waddr;
   logic [SYM_W-1:0]    tape_wdata;
   logic [SYM_W-1:0]    tape_rdata;

   logic                rule_we;
   logic [RULE_AW-1:0]  rule_waddr;
   logic [RULE_AW-1:0]  look_addr;
   logic [RULE_W-1:0]   rule_rdata;
   rule_type            rule_wr;
   rule_type            rule_rd;
   logic                rule_wr_ok;

   logic [ASIZE_W-1:0]  n_eff;
   logic [MAX_SYMBOLS-1:0] match;
   logic [COL_W-1:0]    look_col;
   logic                look_found;
   logic                rule_ok;
   logic [HEAD_W-1:0]   head_moved;

   assign clear_done = cmd.clear && (clr_addr_ff == HEAD_W'(TAPE_LEN - 1));
   assign clr_addr_in = clr_addr_ff + HEAD_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_size_ff <= ASIZE_W'(1);
      end else if (csr_we && (csr_index == CSR_ALPHABET_SIZE)) begin
         alpha_size_ff <= csr_wdata[ASIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && (req_func == FUNC_ALPHABET) && (int'(req_column_index) < MAX_SYMBOLS))
      begin
         alpha_ff[req_column_index] <= req_symbol;
      end
   end

   // Rule fields and range check for a rule load.
   assign rule_wr_ok = (req_rule_state != 4'd0) && (int'(req_rule_state) <= MAX_STATES) &&
                       (int'(req_column_index) < MAX_SYMBOLS);
   assign rule_waddr = RULE_AW'((int'(req_rule_state) - 1) * MAX_SYMBOLS +
                                int'(req_column_index));
   assign rule_we    = cmd.load && (req_func == FUNC_RULE) && rule_wr_ok;
   always_comb begin
      rule_wr.present = req_rule_present;
      rule_wr.sym     = req_symbol;
      rule_wr.move    = req_move_dir;
      rule_wr.next    = req_next_state;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_vld_ff <= '0;
      end else if (rule_we) begin
         rule_vld_ff[rule_waddr] <= 1'b1;
      end
   end

   // Alphabet search on the cell read under the head.
   always_comb begin
      n_eff = (int'(alpha_size_ff) > MAX_SYMBOLS) ? ASIZE_W'(MAX_SYMBOLS) : alpha_size_ff;
      for (int c = 0; c < MAX_SYMBOLS; c++) begin
         match[c] = (c < int'(n_eff)) && (alpha_ff[c] == tape_rdata);
      end
      look_col   = '0;
      look_found = 1'b0;
      for (int c = MAX_SYMBOLS - 1; c >= 0; c--) begin
         if (match[c]) begin
            look_col   = COL_W'(c);
            look_found = 1'b1;
         end
      end
   end

   assign look_addr = RULE_AW'((int'(state_ff) - 1) * MAX_SYMBOLS + int'(look_col));

   always_ff @(posedge clock) begin
      if (cmd.look) begin
         cur_ff    <= tape_rdata;
         found_ff  <= look_found;
         vld_rd_ff <= rule_vld_ff[look_addr];
      end
   end

   assign rule_rd = rule_type'(rule_rdata);
   assign rule_ok = found_ff && vld_rd_ff && rule_rd.present &&
                    (int'(rule_rd.next) <= MAX_STATES);

   always_comb begin
      head_moved = head_ff;
      if (rule_rd.move == MOVE_RIGHT) begin
         head_moved = (head_ff == HEAD_W'(TAPE_LEN - 1)) ? '0 : head_ff + HEAD_W'(1);
      end else if (rule_rd.move == MOVE_LEFT) begin
         head_moved = (head_ff == '0) ? HEAD_W'(TAPE_LEN - 1) : head_ff - HEAD_W'(1);
      end
   end

   always_comb begin
      head_in        = head_ff;
      state_in       = state_ff;
      rsp_outcome_in = OUT_OK;
      rsp_sym_in     = '0;
      if (cmd.load && (req_func == FUNC_HEAD)) begin
         head_in = req_cell_position;
      end
      if (cmd.apply) begin
         rsp_sym_in = cur_ff;
         if (!found_ff) begin
            state_in       = STATE_START;
            rsp_outcome_in = OUT_NO_SYM;
         end else if (!rule_ok) begin
            state_in       = STATE_START;
            rsp_outcome_in = OUT_NO_RULE;
         end else begin
            head_in    = head_moved;
            rsp_sym_in = rule_rd.sym;
            if (rule_rd.next == STATE_HALT) begin
               state_in       = STATE_START;
               rsp_outcome_in = OUT_HALT;
            end else begin
               state_in       = rule_rd.next;
               rsp_outcome_in = OUT_OK;
            end
         end
      end
   end

   always_comb begin
      tape_we    = 1'b0;
      tape_waddr = head_ff;
      tape_wdata = rule_rd.sym;
      if (cmd.clear) begin
         tape_we    = 1'b1;
         tape_waddr = clr_addr_ff;
         tape_wdata = BLANK_RESET;
      end else if (cmd.load && (req_func == FUNC_TAPE)) begin
         tape_we    = 1'b1;
         tape_waddr = req_cell_position;
         tape_wdata = req_symbol;
      end else if (cmd.apply && rule_ok) begin
         tape_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= HEAD_RESET;
         state_ff     <= STATE_START;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.load || cmd.apply;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load || cmd.apply) begin
         rsp_outcome_ff <= rsp_outcome_in;
         rsp_head_ff    <= head_in;
         rsp_state_ff   <= state_in;
         rsp_sym_ff     <= rsp_sym_in;
      end
   end

   tmse_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TAPE_LEN)
   ) u_tape (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_addr (head_ff),
      .rd_data (tape_rdata)
   );

   tmse_ram #(
      .WIDTH (RULE_W),
      .DEPTH (RULE_DEPTH)
   ) u_rules (
      .clock   (clock),
      .wr_en   (rule_we),
      .wr_addr (rule_waddr),
      .wr_data (rule_wr),
      .rd_addr (look_addr),
      .rd_data (rule_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_outcome        = rsp_outcome_ff;
   assign rsp_head_now       = rsp_head_ff;
   assign rsp_state_now      = rsp_state_ff;
   assign rsp_symbol_written = rsp_sym_ff;

endmodule
